@@ sv/ile_pkg.sv @@
// ile_pkg: shared types and constants for the indexed list engine.
// Used by ile_ctrl, ile_dp, indexed_list_engine and ile_checker.
package ile_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 2;
	localparam int FOUND_W  = 4;
	localparam int LEN_W    = 5;
	localparam int OP_W     = 3;

	localparam int S_FIELDS_W = OP_W + POS_W + HANDLE_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = STATUS_W + HANDLE_W + FOUND_W + LEN_W + 1;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_GET    = 3'd2,
		OP_SET    = 3'd3,
		OP_REMOVE = 3'd4,
		OP_POP    = 3'd5,
		OP_FIND   = 3'd6,
		OP_CLEAR  = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ile_cmd_t;

endpackage

@@ sv/ile_ctrl.sv @@
// ile_ctrl: command sequencer and output word valid for the indexed list engine.
// Depends on ile_pkg.
module ile_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output ile_pkg::ile_cmd_t  cmd
);

	ile_pkg::ctrl_state_t state_q, state_d;
	logic                 out_valid_q;
	logic                 can_write;

	assign can_write = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ile_pkg::CS_IDLE: begin
				if (s_tvalid) state_d = ile_pkg::CS_EXEC;
			end
			ile_pkg::CS_EXEC: begin
				if (can_write) state_d = ile_pkg::CS_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ile_pkg::CS_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ile_pkg::CS_EXEC: begin
				cmd.exec = can_write;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ile_pkg::CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ sv/ile_dp.sv @@
// ile_dp: command register, row of list cells with shift paths, search and result word.
// Depends on ile_pkg.
module ile_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ile_pkg::ile_cmd_t             cmd,
	input  logic [ile_pkg::S_DATA_W-1:0]  s_tdata,
	output logic [ile_pkg::M_DATA_W-1:0]  m_tdata
);

	ile_pkg::op_t                   op_q;
	logic [ile_pkg::POS_W-1:0]      pos_q;
	logic [ile_pkg::HANDLE_W-1:0]   handle_q;
	logic [ile_pkg::HANDLE_W-1:0]   entries_q [ile_pkg::CAPACITY];
	logic [ile_pkg::HANDLE_W-1:0]   entries_d [ile_pkg::CAPACITY];
	logic [ile_pkg::CNT_W-1:0]      count_q, count_d;

	ile_pkg::status_t               status_d, status_q;
	logic [ile_pkg::HANDLE_W-1:0]   data_d, data_q;
	logic [ile_pkg::IDX_W-1:0]      found_d;
	logic [ile_pkg::FOUND_W-1:0]    found_q;
	logic [ile_pkg::LEN_W-1:0]      length_q;
	logic                           empty_q;

	logic [ile_pkg::CMP_W-1:0]      pos_ext, count_ext;
	logic                           full;

	assign pos_ext   = ile_pkg::CMP_W'(pos_q);
	assign count_ext = ile_pkg::CMP_W'(count_q);
	assign full      = (count_q == ile_pkg::CNT_W'(ile_pkg::CAPACITY));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= ile_pkg::op_t'(s_tdata[ile_pkg::OP_W-1:0]);
			pos_q    <= s_tdata[ile_pkg::OP_W +: ile_pkg::POS_W];
			handle_q <= s_tdata[ile_pkg::OP_W + ile_pkg::POS_W +: ile_pkg::HANDLE_W];
		end
	end

	always_comb begin
		entries_d = entries_q;
		count_d   = count_q;
		status_d  = ile_pkg::ST_OK;
		data_d    = '0;
		found_d   = '0;
		unique case (op_q)
			ile_pkg::OP_APPEND: begin
				if (full) begin
					status_d = ile_pkg::ST_FULL;
				end else begin
					entries_d[count_q[ile_pkg::IDX_W-1:0]] = handle_q;
					count_d = count_q + 1'b1;
				end
			end
			ile_pkg::OP_INSERT: begin
				if (pos_ext > count_ext) begin
					status_d = ile_pkg::ST_INDEX;
				end else if (full) begin
					status_d = ile_pkg::ST_FULL;
				end else begin
					for (int k = 1; k < ile_pkg::CAPACITY; k++) begin
						if (ile_pkg::CMP_W'(k) > pos_ext) entries_d[k] = entries_q[k-1];
					end
					entries_d[pos_q[ile_pkg::IDX_W-1:0]] = handle_q;
					count_d = count_q + 1'b1;
				end
			end
			ile_pkg::OP_GET: begin
				if (pos_ext < count_ext) data_d = entries_q[pos_q[ile_pkg::IDX_W-1:0]];
				else status_d = ile_pkg::ST_INDEX;
			end
			ile_pkg::OP_SET: begin
				if (pos_ext < count_ext) entries_d[pos_q[ile_pkg::IDX_W-1:0]] = handle_q;
				else status_d = ile_pkg::ST_INDEX;
			end
			ile_pkg::OP_REMOVE, ile_pkg::OP_POP: begin
				if (pos_ext < count_ext) begin
					if (op_q == ile_pkg::OP_POP)
						data_d = entries_q[pos_q[ile_pkg::IDX_W-1:0]];
					for (int k = 0; k < ile_pkg::CAPACITY - 1; k++) begin
						if (ile_pkg::CMP_W'(k) >= pos_ext) entries_d[k] = entries_q[k+1];
					end
					count_d = count_q - 1'b1;
				end else begin
					status_d = ile_pkg::ST_INDEX;
				end
			end
			ile_pkg::OP_FIND: begin
				status_d = ile_pkg::ST_MISS;
				// lowest matching cell wins
				for (int k = ile_pkg::CAPACITY - 1; k >= 0; k--) begin
					if (ile_pkg::CNT_W'(k) < count_q && entries_q[k] == handle_q) begin
						status_d = ile_pkg::ST_OK;
						found_d  = ile_pkg::IDX_W'(k);
					end
				end
			end
			ile_pkg::OP_CLEAR: begin
				count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			entries_q <= entries_d;
			status_q  <= status_d;
			data_q    <= data_d;
			found_q   <= ile_pkg::FOUND_W'(found_d);
			length_q  <= ile_pkg::LEN_W'(count_d);
			empty_q   <= (count_d == '0);
		end
	end

	assign m_tdata = ile_pkg::M_DATA_W'({empty_q, length_q, found_q, data_q, status_q});

endmodule

@@ sv/indexed_list_engine.sv @@
// indexed_list_engine: ordered list of up to CAPACITY handles, one command per word.
// Each accepted word is held in the command register, then executed into the result
// register once the output register is free or being read; the load/execute sequencer
// takes no new word meanwhile, but the next word is taken while a result waits in the output register.
// Reset (arst_n low): list empty, no result pending; cell contents are not cleared.
// Depends on ile_pkg, ile_ctrl and ile_dp.
module indexed_list_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ile_pkg::S_DATA_W-1:0]  s_tdata,  // op[2:0], item_index[10:3], handle[42:11]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ile_pkg::M_DATA_W-1:0]  m_tdata   // status[1:0], data_out[33:2],
	                                                // found_index[37:34], length[42:38],
	                                                // is_empty[43]
);

	ile_pkg::ile_cmd_t cmd;

	ile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ile_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule

@@ sv/ile_checker.sv @@
// ile_checker: port-level assertions for indexed_list_engine, bound to the top level.
// Depends on ile_pkg.
module ile_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ile_pkg::M_DATA_W-1:0]  m_tdata
);

	logic [1:0]  st;
	logic [31:0] dout;
	logic [4:0]  len;
	logic        empty;

	assign st    = m_tdata[1:0];
	assign dout  = m_tdata[33:2];
	assign len   = m_tdata[42:38];
	assign empty = m_tdata[43];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is executing");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> len <= 5'(ile_pkg::CAPACITY))
		else $error("length beyond capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> empty == (len == 5'd0))
		else $error("empty flag disagrees with length");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ile_pkg::ST_OK |-> dout == 32'd0)
		else $error("data on failed command");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ sim/indexed_list_engine_tb.sv @@
`timescale 1ns / 1ps
// indexed_list_engine_tb: self-checking bench for the indexed list engine.
// Predicts every result word from a shadow list and checks it against the output stream.
// Depends on ile_pkg and indexed_list_engine.
module indexed_list_engine_tb;

	localparam int NUM_RANDOM  = 1200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		ile_pkg::op_t op;
		logic [7:0]   index;
		logic [31:0]  handle;
		bit           drain;
	} list_cmd_t;

	typedef struct {
		ile_pkg::status_t status;
		logic [31:0]      data;
		logic [3:0]       found;
		logic [4:0]       length;
		logic             empty;
	} list_result_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [ile_pkg::S_DATA_W-1:0] s_tdata  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [ile_pkg::M_DATA_W-1:0] m_tdata;

	list_cmd_t    pending_cmds[$];
	list_result_t expected_results[$];
	list_cmd_t    cur_cmd;

	logic [31:0] shadow_list[ile_pkg::CAPACITY];
	int          shadow_len = 0;
	int          gen_len = 0;

	int sent_cnt = 0;
	int rcvd_cnt = 0;
	int total_cmds = 0;
	int errors = 0;
	int cycles = 0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_hold = 0;
	int ready_cycle = 0;
	int status_seen[4] = '{0, 0, 0, 0};

	indexed_list_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic list_result_t apply_command(list_cmd_t c);
		list_result_t r;
		int k;
		r.status = ile_pkg::ST_OK;
		r.data   = '0;
		r.found  = '0;
		case (c.op)
			ile_pkg::OP_APPEND: begin
				if (shadow_len >= ile_pkg::CAPACITY) begin
					r.status = ile_pkg::ST_FULL;
				end else begin
					shadow_list[shadow_len] = c.handle;
					shadow_len++;
				end
			end
			ile_pkg::OP_INSERT: begin
				if (c.index > shadow_len) begin
					r.status = ile_pkg::ST_INDEX;
				end else if (shadow_len >= ile_pkg::CAPACITY) begin
					r.status = ile_pkg::ST_FULL;
				end else begin
					for (k = shadow_len; k > c.index; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[c.index] = c.handle;
					shadow_len++;
				end
			end
			ile_pkg::OP_GET: begin
				if (c.index < shadow_len)
					r.data = shadow_list[c.index];
				else
					r.status = ile_pkg::ST_INDEX;
			end
			ile_pkg::OP_SET: begin
				if (c.index < shadow_len)
					shadow_list[c.index] = c.handle;
				else
					r.status = ile_pkg::ST_INDEX;
			end
			ile_pkg::OP_REMOVE, ile_pkg::OP_POP: begin
				if (c.index < shadow_len) begin
					if (c.op == ile_pkg::OP_POP)
						r.data = shadow_list[c.index];
					for (k = c.index; k < shadow_len - 1; k++)
						shadow_list[k] = shadow_list[k+1];
					shadow_len--;
				end else begin
					r.status = ile_pkg::ST_INDEX;
				end
			end
			ile_pkg::OP_FIND: begin
				r.status = ile_pkg::ST_MISS;
				for (k = 0; k < shadow_len; k++) begin
					if (r.status == ile_pkg::ST_MISS && shadow_list[k] == c.handle) begin
						r.status = ile_pkg::ST_OK;
						r.found  = k[3:0];
					end
				end
			end
			default: begin
				shadow_len = 0;
			end
		endcase
		r.length = shadow_len[4:0];
		r.empty  = (shadow_len == 0);
		return r;
	endfunction

	task automatic add_cmd(ile_pkg::op_t op, int index, logic [31:0] handle,
	                       bit drain = 1'b0);
		list_cmd_t c;
		c.op     = op;
		c.index  = index[7:0];
		c.handle = handle;
		c.drain  = drain;
		case (op)
			ile_pkg::OP_APPEND: if (gen_len < ile_pkg::CAPACITY) gen_len++;
			ile_pkg::OP_INSERT:
				if (c.index <= gen_len && gen_len < ile_pkg::CAPACITY) gen_len++;
			ile_pkg::OP_REMOVE, ile_pkg::OP_POP: if (c.index < gen_len) gen_len--;
			ile_pkg::OP_CLEAR: gen_len = 0;
			default: ;
		endcase
		pending_cmds.push_back(c);
	endtask

	task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
			errors++;
		end
	endtask

	// driver: bursts with random gaps; a drain-marked word waits for all results
	always @(posedge clk or negedge arst_n) begin : driver
		int next_sent;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			sent_cnt <= 0;
		end else begin
			next_sent = sent_cnt;
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_command(cur_cmd));
				next_sent++;
				sent_cnt <= next_sent;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0 &&
				             !(pending_cmds[0].drain && next_sent != rcvd_cnt)) begin
					cur_cmd = pending_cmds.pop_front();
					s_tdata  <= ile_pkg::S_DATA_W'({cur_cmd.handle, cur_cmd.index, cur_cmd.op});
					s_tvalid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						                                         : $urandom_range(0, 8);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks result words and drives tready on a changing stall pattern
	always @(posedge clk or negedge arst_n) begin : monitor
		list_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rcvd_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rcvd_cnt == sent_cnt) begin
					$display("%0t: unexpected result word, expected none, actual %h",
					         $time, m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					rcvd_cnt <= rcvd_cnt + 1;
					check_field("status", want.status, m_tdata[1:0]);
					check_field("data_out", want.data, m_tdata[33:2]);
					check_field("found_index", want.found, m_tdata[37:34]);
					check_field("length", want.length, m_tdata[42:38]);
					check_field("is_empty", want.empty, m_tdata[43]);
					status_seen[m_tdata[1:0]]++;
				end
			end
			if (ready_cycle % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			ready_cycle++;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				2: m_tready <= (ready_cycle % 4 == 0);
				default: begin
					if (stall_hold == 0) begin
						stall_hold = $urandom_range(0, 15);
						m_tready <= 1'b1;
					end else begin
						stall_hold--;
						m_tready <= 1'b0;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** indexed_list_engine: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [31:0]  pool[8];
		logic [31:0]  h;
		ile_pkg::op_t op;
		int           pick, sel, idx, phase, phase_left;

		phase = 0;
		phase_left = 0;
		foreach (pool[i])
			pool[i] = $urandom;

		// empty list corner cases
		add_cmd(ile_pkg::OP_FIND, 0, 32'h0);
		add_cmd(ile_pkg::OP_GET, 0, 32'h0);
		add_cmd(ile_pkg::OP_SET, 0, 32'hFFFF_FFFF);
		add_cmd(ile_pkg::OP_REMOVE, 0, 32'h0);
		add_cmd(ile_pkg::OP_POP, 255, 32'h0);
		add_cmd(ile_pkg::OP_INSERT, 1, 32'h1);
		add_cmd(ile_pkg::OP_CLEAR, 0, 32'h0);
		// build a short list, touch both ends and the middle
		add_cmd(ile_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
		add_cmd(ile_pkg::OP_APPEND, 0, 32'h0);
		add_cmd(ile_pkg::OP_APPEND, 0, 32'h8000_0001);
		add_cmd(ile_pkg::OP_INSERT, 3, 32'h1234_5678);
		add_cmd(ile_pkg::OP_INSERT, 1, 32'h5A5A_5A5A);
		add_cmd(ile_pkg::OP_GET, 4, 32'h0);
		add_cmd(ile_pkg::OP_GET, 5, 32'h0);
		add_cmd(ile_pkg::OP_SET, 2, 32'hFFFF_FFFF);
		add_cmd(ile_pkg::OP_FIND, 0, 32'hFFFF_FFFF);
		add_cmd(ile_pkg::OP_FIND, 0, 32'hDEAD_BEEF);
		add_cmd(ile_pkg::OP_POP, 1, 32'h0);
		add_cmd(ile_pkg::OP_REMOVE, 0, 32'h0);
		add_cmd(ile_pkg::OP_POP, 2, 32'h0);
		add_cmd(ile_pkg::OP_INSERT, 200, 32'h0);
		add_cmd(ile_pkg::OP_CLEAR, 0, 32'h0);

		// random: grow, shrink and mixed phases
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (phase_left == 0) begin
				phase = $urandom_range(0, 2);
				phase_left = $urandom_range(10, 40);
			end
			phase_left--;
			pick = $urandom_range(0, 99);
			if (phase == 0) begin
				if (pick < 45)      op = ile_pkg::OP_APPEND;
				else if (pick < 80) op = ile_pkg::OP_INSERT;
				else if (pick < 88) op = ile_pkg::OP_GET;
				else if (pick < 94) op = ile_pkg::OP_SET;
				else if (pick < 98) op = ile_pkg::OP_FIND;
				else                op = ile_pkg::OP_REMOVE;
			end else if (phase == 1) begin
				if (pick < 35)      op = ile_pkg::OP_REMOVE;
				else if (pick < 70) op = ile_pkg::OP_POP;
				else if (pick < 80) op = ile_pkg::OP_GET;
				else if (pick < 88) op = ile_pkg::OP_FIND;
				else if (pick < 93) op = ile_pkg::OP_SET;
				else if (pick < 98) op = ile_pkg::OP_APPEND;
				else                op = ile_pkg::OP_CLEAR;
			end else begin
				op = (pick < 97) ? ile_pkg::op_t'($urandom_range(0, 6)) : ile_pkg::OP_CLEAR;
			end

			sel = $urandom_range(0, 19);
			if (sel < 15) begin
				if (op == ile_pkg::OP_INSERT)
					idx = $urandom_range(0, gen_len);
				else
					idx = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
			end else if (sel < 18) begin
				idx = gen_len + $urandom_range(0, 2);
			end else begin
				idx = $urandom_range(0, 255);
			end

			sel = $urandom_range(0, 19);
			if (sel < 12)       h = pool[$urandom_range(0, 7)];
			else if (sel == 12) h = 32'h0;
			else if (sel == 13) h = 32'hFFFF_FFFF;
			else                h = $urandom;

			add_cmd(op, idx, h, (n % 300 == 0));
		end
		total_cmds = pending_cmds.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_cnt != total_cmds || rcvd_cnt != sent_cnt)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t: %0d results still outstanding, expected 0, actual %0d",
			         $time, expected_results.size(), expected_results.size());
			errors++;
		end

		$display("Checked %0d command words: %0d ok, %0d bad index, %0d list full, %0d not found",
		         rcvd_cnt, status_seen[ile_pkg::ST_OK], status_seen[ile_pkg::ST_INDEX],
		         status_seen[ile_pkg::ST_FULL], status_seen[ile_pkg::ST_MISS]);
		if (errors == 0)
			$display("** indexed_list_engine: PASSED **");
		else
			$display("** indexed_list_engine: FAILED **");
		$finish;
	end

endmodule
